/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/bedr_pkg.sv */
`default_nettype none
package bedr_pkg;
   localparam int BUTTON_COUNT_DEF = 5;
   localparam int KEY_COUNT_DEF    = 32;
   localparam int CLOCK_W          = 48;
   localparam int HOLD_W           = 32;
   localparam int TIME_W           = 22;
   localparam int RAD_W            = 10;
   localparam int FRAME_W          = 20;
   localparam int POS_W            = 16;
   localparam int CSR_IDX_W        = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_DC_WINDOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_RADIUS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RPT_DELAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RPT_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAG_RAD   = 3'd4;

   // Request to the shared repeat unit for one channel.
   typedef struct packed {
      logic                start;
      logic [HOLD_W:0]     excess;  // hold minus delay, positive whenever start is set
      logic [TIME_W-1:0]   period;
      logic [FRAME_W-1:0]  frame_us;
   } rpt_req_type;

   typedef struct packed {
      logic done;
      logic fire;
   } rpt_rsp_type;
endpackage
`default_nettype wire

/* rtl/core/bedr_mod_unit.sv */
`default_nettype none
// Restoring remainder of excess by period, one quotient bit per cycle, then
// compares the remainder with the frame time.
module bedr_mod_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bedr_pkg::rpt_req_type req,
   output bedr_pkg::rpt_rsp_type     rsp
);
   localparam int NW = bedr_pkg::HOLD_W + 1;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]            num_ff, num_in;
   logic [NW-1:0]            rem_ff, rem_in;
   logic [bedr_pkg::TIME_W-1:0] per_ff, per_in;
   logic [bedr_pkg::FRAME_W-1:0] dt_ff, dt_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     fire_ff, fire_in;
   logic [NW:0]              trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      per_in  = per_ff;
      dt_in   = dt_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      fire_in = fire_ff;
      trial   = {rem_ff, num_ff[NW-1]};
      if (req.start) begin
         num_in  = req.excess;
         rem_in  = '0;
         per_in  = (req.period == '0) ? bedr_pkg::TIME_W'(1) : req.period;
         dt_in   = req.frame_us;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {(NW+1-bedr_pkg::TIME_W)'(0), per_ff})
            rem_in = NW'(trial - {(NW+1-bedr_pkg::TIME_W)'(0), per_ff});
         else
            rem_in = NW'(trial);
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            fire_in = rem_in < {(NW-bedr_pkg::FRAME_W)'(0), dt_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      per_ff  <= per_in;
      dt_ff   <= dt_in;
      fire_ff <= fire_in;
   end

   assign rsp.done = done_ff;
   assign rsp.fire = fire_ff;
endmodule
`default_nettype wire

/* rtl/core/button_edge_doubleclick_repeat_unit.sv */
`default_nettype none
// An item is accepted in the idle state. Each channel then passes ST_CHAN, buttons also
// ST_DIST, and ST_WAIT; a held channel past the repeat delay waits there for the shared
// 33-step remainder unit. ST_OUT then shows the result. One item at a time: the next is
// accepted once the result is shown, also while it waits for the receiver; a result
// stalled by the receiver holds back only the next one. Synchronous active-high reset
// restores register defaults.
module button_edge_doubleclick_repeat_unit #(
   parameter int BUTTON_COUNT = bedr_pkg::BUTTON_COUNT_DEF,
   parameter int KEY_COUNT    = bedr_pkg::KEY_COUNT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // frame_us[19:0], pointer_x[35:20], pointer_y[51:36], buttons_held,
   // keys_held, zero fill
   input  wire logic [((bedr_pkg::FRAME_W+2*bedr_pkg::POS_W+BUTTON_COUNT+KEY_COUNT+7)/8)*8-1:0]
                              req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // button_pressed, button_let_go, button_double, button_repeat,
   // button_dragging, key_pressed, key_let_go, key_repeat, zero fill
   output logic [((5*BUTTON_COUNT+3*KEY_COUNT+7)/8)*8-1:0] rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [bedr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bedr_pkg::TIME_W-1:0]    csr_wdata
);
   localparam int B   = BUTTON_COUNT;
   localparam int K   = KEY_COUNT;
   localparam int N   = B + K;
   localparam int OW  = ((5*B+3*K+7)/8)*8;
   localparam int CHW = (N > 1) ? $clog2(N) : 1;
   localparam int BIW = (B > 1) ? $clog2(B) : 1;
   localparam int PW  = bedr_pkg::POS_W;
   localparam int CW  = bedr_pkg::CLOCK_W;
   localparam int HW  = bedr_pkg::HOLD_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHAN, ST_WAIT, ST_DIST, ST_OUT
   } state_type;

   state_type state_ff;

   logic [bedr_pkg::TIME_W-1:0] dc_win_ff, rpt_delay_ff, rpt_period_ff;
   logic [bedr_pkg::RAD_W-1:0]  dc_rad_ff, drag_rad_ff;

   logic [B-1:0]    prev_b_ff;
   logic [K-1:0]    prev_k_ff;
   logic [CW-1:0]   clk_ff;
   // A hold time is always written on its channel's press frame before its value
   // is used, so the store needs no clearing after reset.
   logic [HW-1:0]   hold_ff [N];
   logic [HW-1:0]   hold_rd_ff;
   logic            run_ff;
   logic [CW-1:0]   ct_ff [B];
   logic [PW-1:0]   cx_ff [B];
   logic [PW-1:0]   cy_ff [B];

   logic [bedr_pkg::FRAME_W-1:0] dt_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   logic [B-1:0]    bh_ff;
   logic [K-1:0]    kh_ff;
   logic [N-1:0]    rep_ff;
   logic [B-1:0]    dbl_ff, drag_ff;
   logic [CHW-1:0]  ch_ff;
   logic [OW-1:0]   out_ff;

   // distance pipeline registers
   logic signed [PW:0]     dx_ff, dy_ff;
   logic [2*PW+1:0]        dd_ff;
   logic                   dist_pass_ff;  // 0: square dx, 1: add dy squared and test
   logic [2*bedr_pkg::RAD_W-1:0] r2_dc, r2_dr;

   logic [N-1:0] was_v, is_v;
   logic         was_c, is_c;
   logic [HW:0]  hsum;
   logic [HW-1:0] hsat;
   bedr_pkg::rpt_req_type mreq;
   bedr_pkg::rpt_rsp_type mrsp;
   logic [CW-1:0] gap;
   logic [BIW-1:0] bi;

   assign was_v = {prev_k_ff, prev_b_ff};
   assign is_v  = {kh_ff, bh_ff};
   assign was_c = was_v[ch_ff];
   assign is_c  = is_v[ch_ff];
   assign hsum  = {1'b0, hold_rd_ff} + {(HW+1-bedr_pkg::FRAME_W)'(0), dt_ff};
   assign hsat  = hsum[HW] ? '1 : hsum[HW-1:0];
   assign r2_dc = dc_rad_ff * dc_rad_ff;
   assign r2_dr = drag_rad_ff * drag_rad_ff;
   assign bi    = ch_ff[BIW-1:0];
   assign gap   = clk_ff - ct_ff[bi];

   bedr_mod_unit u_mod (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   always_comb begin
      mreq.start    = (state_ff == ST_CHAN) && is_c && was_c &&
                      ({1'b0, hsat} > {(HW+1-bedr_pkg::TIME_W)'(0), rpt_delay_ff});
      mreq.excess   = {1'b0, hsat} - {(HW+1-bedr_pkg::TIME_W)'(0), rpt_delay_ff};
      mreq.period   = rpt_period_ff;
      mreq.frame_us = dt_ff;
   end

   // The result register parts the two sides: a new item may be taken while
   // the previous result still waits for the receiver.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid    <= 1'b0;
         dc_win_ff     <= bedr_pkg::TIME_W'(300000);
         dc_rad_ff     <= bedr_pkg::RAD_W'(6);
         rpt_delay_ff  <= bedr_pkg::TIME_W'(250000);
         rpt_period_ff <= bedr_pkg::TIME_W'(50000);
         drag_rad_ff   <= bedr_pkg::RAD_W'(6);
         prev_b_ff     <= '0;
         prev_k_ff     <= '0;
         clk_ff        <= '0;
         ch_ff         <= '0;
         for (int i = 0; i < B; i++) begin
            ct_ff[i] <= '0;
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               bedr_pkg::CSR_DC_WINDOW:  dc_win_ff     <= csr_wdata;
               bedr_pkg::CSR_DC_RADIUS:  dc_rad_ff     <= csr_wdata[bedr_pkg::RAD_W-1:0];
               bedr_pkg::CSR_RPT_DELAY:  rpt_delay_ff  <= csr_wdata;
               bedr_pkg::CSR_RPT_PERIOD: rpt_period_ff <= csr_wdata;
               bedr_pkg::CSR_DRAG_RAD:   drag_rad_ff   <= csr_wdata[bedr_pkg::RAD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready && state_ff != ST_OUT) rsp_tvalid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  dt_ff  <= req_tdata[bedr_pkg::FRAME_W-1:0];
                  px_ff  <= req_tdata[bedr_pkg::FRAME_W +: PW];
                  py_ff  <= req_tdata[bedr_pkg::FRAME_W+PW +: PW];
                  bh_ff  <= req_tdata[bedr_pkg::FRAME_W+2*PW +: B];
                  kh_ff  <= req_tdata[bedr_pkg::FRAME_W+2*PW+B +: K];
                  clk_ff <= clk_ff + CW'(req_tdata[bedr_pkg::FRAME_W-1:0]);
                  ch_ff  <= '0;
                  hold_rd_ff <= hold_ff[0];
                  dist_pass_ff <= 1'b0;
                  state_ff <= ST_CHAN;
               end
            end
            ST_CHAN: begin
               // Hold time update; buttons then get the distance passes.
               rep_ff[ch_ff] <= is_c && !was_c;
               run_ff <= mreq.start;
               if (!is_c || !was_c) hold_ff[ch_ff] <= '0;
               else hold_ff[ch_ff] <= hsat;
               if ({1'b0, ch_ff} < (CHW+1)'(B)) begin
                  dx_ff <= (PW+1)'(px_ff) - (PW+1)'($signed(cx_ff[bi]));
                  dy_ff <= (PW+1)'(py_ff) - (PW+1)'($signed(cy_ff[bi]));
                  dist_pass_ff <= 1'b0;
                  state_ff <= ST_DIST;
               end else state_ff <= ST_WAIT;
            end
            ST_DIST: begin
               // One square a cycle: first dx, then dy.
               if (!dist_pass_ff) begin
                  dd_ff <= (2*PW+2)'($unsigned((2*PW+2)'(dx_ff) * (2*PW+2)'(dx_ff)));
                  dist_pass_ff <= 1'b1;
               end else begin
                  logic [2*PW+2:0] d2;
                  d2 = {1'b0, dd_ff} +
                       (2*PW+3)'($unsigned((2*PW+2)'(dy_ff) * (2*PW+2)'(dy_ff)));
                  if (is_c && !was_c) begin
                     dbl_ff[bi] <= (gap < CW'(dc_win_ff)) && (d2 < (2*PW+3)'(r2_dc));
                     ct_ff[bi] <= clk_ff;
                     cx_ff[bi] <= px_ff;
                     cy_ff[bi] <= py_ff;
                     drag_ff[bi] <= 1'b0 >= (r2_dr != '0) ? 1'b1 : 1'b0;
                  end else begin
                     dbl_ff[bi] <= 1'b0;
                     drag_ff[bi] <= is_c && (d2 >= (2*PW+3)'(r2_dr));
                  end
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               // The unit was started in ST_CHAN if the hold passed the delay.
               if (!run_ff || mrsp.done) begin
                  if (run_ff)
                     rep_ff[ch_ff] <= mrsp.fire;
                  if (ch_ff == CHW'(N-1)) state_ff <= ST_OUT;
                  else begin
                     ch_ff <= ch_ff + CHW'(1);
                     hold_rd_ff <= hold_ff[ch_ff + CHW'(1)];
                     state_ff <= ST_CHAN;
                  end
               end
            end
            ST_OUT: begin
               // Wait here while the previous result is still unclaimed.
               if (!rsp_tvalid || rsp_tready) begin
                  out_ff <= OW'({rep_ff[N-1:B], prev_k_ff & ~kh_ff, kh_ff & ~prev_k_ff,
                                 drag_ff, rep_ff[B-1:0], dbl_ff,
                                 prev_b_ff & ~bh_ff, bh_ff & ~prev_b_ff});
                  prev_b_ff  <= bh_ff;
                  prev_k_ff  <= kh_ff;
                  rsp_tvalid <= 1'b1;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`include "assert_macros.svh"
   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_tready, "accept while busy")
   `ASSERT_IMPL(a_unit_only_wait, clock, reset, mrsp.done, state_ff == ST_WAIT, "unit done outside wait")
   `ASSERT_IMPL(a_out_sets_valid, clock, reset, state_ff == ST_OUT, ##1 rsp_tvalid, "result not shown")
endmodule
`default_nettype wire
